/* rtl/core/wim_pkg.sv */
// Package for the wide integer multiplier unit.
// Holds sizes, digit types and the control struct between sequencer and MAC.
// No dependencies.
package wim_pkg;

  localparam int DIGITS = 256;
  localparam int ADDR_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int POS_W  = $clog2(DIGITS + 1);
  localparam int DIG_W  = 8;
  localparam int PROD_W = 2 * DIG_W;
  localparam int CARRY_W = 32;
  localparam int ACC_W  = CARRY_W + DIG_W;

  typedef logic [DIG_W-1:0]   digit_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [POS_W-1:0]   pos_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic commit;
    logic over;
    logic last;
  } mac_ctl_t;

endpackage

/* rtl/core/wim_if.sv */
// Channel interfaces for the wide integer multiplier unit.
// Depends on wim_pkg.
interface wim_in_if import wim_pkg::*; ();
  logic   valid;
  logic   ready;
  digit_t lhs_digit;
  digit_t rhs_digit;
  logic   final_digit;

  modport source (output valid, lhs_digit, rhs_digit, final_digit, input ready);
  modport sink (input valid, lhs_digit, rhs_digit, final_digit, output ready);
endinterface

interface wim_out_if import wim_pkg::*; ();
  logic   valid;
  logic   ready;
  digit_t product_digit;
  logic   final_out;
  logic   too_many_digits;

  modport source (output valid, product_digit, final_out, too_many_digits, input ready);
  modport sink (input valid, product_digit, final_out, too_many_digits, output ready);
endinterface

/* rtl/core/wim_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/wim_mac.sv */
// Multiply-accumulate datapath: one 8x8 multiplier, column accumulator, carry.
// Depends on wim_pkg.
module wim_mac import wim_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_ctl_t ctl,
  input  digit_t   lhs_q,
  input  digit_t   rhs_q,
  output logic     busy,
  output digit_t   acc_digit
);

  logic               v1_r;
  logic               v2_r;
  logic [PROD_W-1:0]  prod_r;
  logic [ACC_W-1:0]   acc_r;
  logic [CARRY_W-1:0] carry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      carry_r <= '0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
      if (ctl.commit) begin
        if (ctl.last) begin
          carry_r <= '0;
        end else if (!ctl.over) begin
          carry_r <= acc_r[ACC_W-1:DIG_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= PROD_W'(lhs_q) * PROD_W'(rhs_q);
    end
    if (ctl.start) begin
      acc_r <= ACC_W'(carry_r);
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign busy      = v1_r | v2_r;
  assign acc_digit = acc_r[DIG_W-1:0];

endmodule

/* rtl/core/wim_seq.sv */
// Sequencer: accepts digit pairs, writes the stores, walks the column
// addresses and holds the result register. Depends on wim_pkg.
module wim_seq import wim_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_final,
  output logic     out_valid,
  input  logic     out_ready,
  output digit_t   out_digit,
  output logic     out_final,
  output logic     out_over,
  output logic     ram_we,
  output addr_t    ram_waddr,
  output addr_t    lhs_raddr,
  output addr_t    rhs_raddr,
  output mac_ctl_t ctl,
  input  logic     mac_busy,
  input  digit_t   acc_digit
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state_r, state_nxt;
  pos_t       pos_r, pos_nxt;
  addr_t      i_r, i_nxt;
  addr_t      k_r, k_nxt;
  logic       final_r, final_nxt;
  logic       over_r, over_nxt;
  logic       out_valid_r, out_valid_nxt;
  digit_t     out_digit_r, out_digit_nxt;
  logic       out_final_r, out_final_nxt;
  logic       out_over_r, out_over_nxt;
  logic       accept;
  logic       full;
  logic       commit;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (pos_r == POS_W'(DIGITS));
  assign commit   = (state_r == S_OUT) && (!out_valid_r || out_ready);

  assign ram_we    = accept && !full;
  assign ram_waddr = pos_r[ADDR_W-1:0];
  assign lhs_raddr = i_r;
  assign rhs_raddr = k_r - i_r;

  assign ctl.start  = ram_we;
  assign ctl.issue  = (state_r == S_READ);
  assign ctl.commit = commit;
  assign ctl.over   = over_r;
  assign ctl.last   = final_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    final_nxt     = final_r;
    over_nxt      = over_r;
    out_valid_nxt = out_valid_r;
    out_digit_nxt = out_digit_r;
    out_final_nxt = out_final_r;
    out_over_nxt  = out_over_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          final_nxt = in_final;
          over_nxt  = full;
          k_nxt     = pos_r[ADDR_W-1:0];
          i_nxt     = '0;
          state_nxt = full ? S_OUT : S_READ;
        end
      end
      S_READ: begin
        if (i_r == k_r) begin
          state_nxt = S_DRAIN;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          out_digit_nxt = over_r ? '0 : acc_digit;
          out_final_nxt = final_r;
          out_over_nxt  = over_r;
          if (final_r) begin
            pos_nxt = '0;
          end else if (!over_r) begin
            pos_nxt = POS_W'(k_r) + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    k_r         <= k_nxt;
    final_r     <= final_nxt;
    over_r      <= over_nxt;
    out_digit_r <= out_digit_nxt;
    out_final_r <= out_final_nxt;
    out_over_r  <= out_over_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_digit = out_digit_r;
  assign out_final = out_final_r;
  assign out_over  = out_over_r;

endmodule

/* rtl/core/wide_integer_multiplier_unit.sv */
// Wide integer multiplier unit, top level: sequencer, two digit stores, MAC.
// Depends on wim_pkg, wim_if, wim_ram, wim_seq and wim_mac.
//
// Digit pairs arrive least significant first; each one yields one product
// digit, the low digits of the product modulo 256^L. Pair k is stored and then
// column k is summed with one 8x8 multiplier, reading one digit from each
// store per cycle; input ready stays low until the column digit has moved
// into the output register. A finished digit waits in the output register
// while the next pair is accepted. Pairs past DIGITS are not stored and
// return digit 0 with too_many_digits set; a final pair ends the run and
// clears position and carry.
module wide_integer_multiplier_unit import wim_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  wim_in_if.sink     in_ch,
  wim_out_if.source  out_ch
);

  logic     ram_we;
  addr_t    ram_waddr;
  addr_t    lhs_raddr;
  addr_t    rhs_raddr;
  digit_t   lhs_q;
  digit_t   rhs_q;
  mac_ctl_t ctl;
  logic     mac_busy;
  digit_t   acc_digit;

  wim_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_final  (in_ch.final_digit),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_digit (out_ch.product_digit),
    .out_final (out_ch.final_out),
    .out_over  (out_ch.too_many_digits),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .lhs_raddr (lhs_raddr),
    .rhs_raddr (rhs_raddr),
    .ctl       (ctl),
    .mac_busy  (mac_busy),
    .acc_digit (acc_digit)
  );

  wim_ram #(.WIDTH(DIG_W), .DEPTH(DIGITS)) u_lhs_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.lhs_digit),
    .raddr (lhs_raddr),
    .rdata (lhs_q)
  );

  wim_ram #(.WIDTH(DIG_W), .DEPTH(DIGITS)) u_rhs_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.rhs_digit),
    .raddr (rhs_raddr),
    .rdata (rhs_q)
  );

  wim_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .lhs_q     (lhs_q),
    .rhs_q     (rhs_q),
    .busy      (mac_busy),
    .acc_digit (acc_digit)
  );

endmodule
